FILE: design/cmad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmad_pkg;

   // Field widths
   localparam int SAMPLE_W = 21;
   localparam int SUM_W    = 24;
   localparam int DECI_W   = 15;
   localparam int DEADBAND_W = 16;

   // Saturation bounds of the held-sample sum
   localparam int SUM_MAX = 8388607;
   localparam int SUM_MIN = -8388608;

   // Serial divider: two quotient bits per cycle over the sum width
   localparam int DIV_DIGITS = SUM_W / 2;
   localparam int DIGIT_W    = $clog2(DIV_DIGITS);

   // Milliamps per tenth of an ampere
   localparam int DECI_DIVISOR = 100;

   // Register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 16'd100;

   typedef enum logic [1:0] {
      REG_DEADBAND   = 2'd0,
      REG_SIM_ENABLE = 2'd1,
      REG_SIM_VALUE  = 2'd2
   } reg_index_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SUM  = 7'b0000010,
      ST_LOAD = 7'b0000100,
      ST_DIV1 = 7'b0001000,
      ST_DEAD = 7'b0010000,
      ST_DIV2 = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

FILE: design/current_moving_average_deadband.sv
// Sequence: an accepted req beat passes through a sum update, a load, the average
//   divider, a deadband step, the divide by 100 and an output step to rsp_valid;
//   the output step holds while the rsp side stalls.
// Pacing: a new beat is taken only in idle, after the last one leaves the output step;
//   the shared 2-bit-per-cycle divider runs twice per beat.
// Reset (synchronous, active high): clears fill count, write slot, sum, state and
//   rsp_valid, and sets the registers to their defaults; the sample ring is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module current_moving_average_deadband #(
   parameter int WINDOW = 8
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // request channel
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic signed [cmad_pkg::SAMPLE_W-1:0]     req_sample_ma,
   // response channel
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic signed [cmad_pkg::SAMPLE_W-1:0]          rsp_avg_current_ma,
   output logic signed [cmad_pkg::DECI_W-1:0]            rsp_avg_current_deci_amp,
   // register port
   input  wire logic                                     psel,
   input  wire logic                                     penable,
   input  wire logic                                     pwrite,
   input  wire logic [cmad_pkg::CSR_ADDR_W-1:0]          paddr,
   input  wire logic [cmad_pkg::CSR_DATA_W-1:0]          pwdata,
   output logic [cmad_pkg::CSR_DATA_W-1:0]               prdata,
   output logic                                          pready
);

   localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW  = $clog2(WINDOW + 1);
   localparam int SW  = cmad_pkg::SAMPLE_W + $clog2(WINDOW);
   localparam int XW  = (SW > cmad_pkg::SUM_W) ? SW : cmad_pkg::SUM_W;
   localparam int DW  = (CW > 7) ? CW : 7;
   localparam int RW  = DW + 1;
   localparam int QW  = cmad_pkg::SUM_W;
   localparam int SMW = cmad_pkg::SAMPLE_W;

   localparam logic signed [XW-1:0] SAT_HI = XW'(cmad_pkg::SUM_MAX);
   localparam logic signed [XW-1:0] SAT_LO = XW'(cmad_pkg::SUM_MIN);

   // Registers
   cmad_pkg::state_type state_ff, state_in;
   logic [AW-1:0]                  write_slot_ff, write_slot_in;
   logic [CW-1:0]                  fill_count_ff, fill_count_in;
   logic                           was_full_ff, was_full_in;
   logic signed [SW-1:0]           sum_ff, sum_in;
   logic signed [SMW-1:0]          sample_ff, sample_in;
   logic signed [SMW-1:0]          evict_ff;
   logic signed [SMW-1:0]          sample_ring_ff [WINDOW];
   logic                           sum_neg_ff, sum_neg_in;
   logic                           res_neg_ff, res_neg_in;
   logic [QW-1:0]                  quot_ff, quot_in;
   logic [RW-1:0]                  rem_ff, rem_in;
   logic [DW-1:0]                  divisor_ff, divisor_in;
   logic [cmad_pkg::DIGIT_W-1:0]   digit_ff, digit_in;
   logic signed [SMW-1:0]          result_ff, result_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SMW-1:0]          rsp_ma_ff, rsp_ma_in;
   logic signed [cmad_pkg::DECI_W-1:0] rsp_deci_ff, rsp_deci_in;
   logic [cmad_pkg::DEADBAND_W-1:0] deadband_ff;
   logic                           sim_enable_ff;
   logic signed [SMW-1:0]          sim_value_ff;

   logic                           req_beat;
   logic                           csr_write;
   logic [1:0]                     csr_index;
   logic signed [XW-1:0]           sum_x;
   logic signed [QW-1:0]           sum_sat;
   logic [QW-1:0]                  sum_mag;
   logic [QW-1:0]                  quot_step;
   logic [RW-1:0]                  rem_step;
   logic                           last_digit;
   logic                           below_deadband;
   logic [SMW-1:0]                 sim_mag;
   logic [SMW-1:0]                 res_mag;
   logic                           res_neg_sel;

   assign req_ready = (state_ff == cmad_pkg::ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_avg_current_ma       = rsp_ma_ff;
   assign rsp_avg_current_deci_amp = rsp_deci_ff;
   assign pready = 1'b1;

   // Register port decode
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff   <= cmad_pkg::DEADBAND_RESET;
         sim_enable_ff <= 1'b0;
         sim_value_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            cmad_pkg::REG_DEADBAND:   deadband_ff   <= pwdata[cmad_pkg::DEADBAND_W-1:0];
            cmad_pkg::REG_SIM_ENABLE: sim_enable_ff <= pwdata[0];
            cmad_pkg::REG_SIM_VALUE:  sim_value_ff  <= pwdata[SMW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         cmad_pkg::REG_DEADBAND:
            prdata = cmad_pkg::CSR_DATA_W'(deadband_ff);
         cmad_pkg::REG_SIM_ENABLE:
            prdata = cmad_pkg::CSR_DATA_W'(sim_enable_ff);
         cmad_pkg::REG_SIM_VALUE:
            prdata = cmad_pkg::CSR_DATA_W'(unsigned'(sim_value_ff));
         default:
            prdata = '0;
      endcase
   end

   // Sample ring: write the new sample, read out the one it replaces
   always_ff @(posedge clock) begin
      if (req_beat) begin
         sample_ring_ff[write_slot_ff] <= req_sample_ma;
         evict_ff <= sample_ring_ff[write_slot_ff];
      end
   end

   // Saturate the exact sum to the sum range and take its magnitude
   assign sum_x   = XW'(sum_ff);
   always_comb begin
      if (sum_x > SAT_HI) begin
         sum_sat = SAT_HI[QW-1:0];
      end else if (sum_x < SAT_LO) begin
         sum_sat = SAT_LO[QW-1:0];
      end else begin
         sum_sat = sum_x[QW-1:0];
      end
      sum_mag = sum_sat[QW-1] ? (~sum_sat + 1'b1) : sum_sat;
   end

   // Divider digit: two restoring steps per cycle
   always_comb begin : div_step
      logic [RW-1:0] r;
      logic [QW-1:0] d;
      r = rem_ff;
      d = quot_ff;
      for (int k = 0; k < 2; k++) begin
         r = {r[RW-2:0], d[QW-1]};
         d = {d[QW-2:0], 1'b0};
         if (r >= {1'b0, divisor_ff}) begin
            r = r - {1'b0, divisor_ff};
            d[0] = 1'b1;
         end
      end
      rem_step  = r;
      quot_step = d;
   end

   assign last_digit = (digit_ff == cmad_pkg::DIGIT_W'(cmad_pkg::DIV_DIGITS - 1));

   // Deadband and override select on the average magnitude
   assign below_deadband = (quot_ff < QW'(deadband_ff));
   assign sim_mag = sim_value_ff[SMW-1] ? (~sim_value_ff + 1'b1) : sim_value_ff;
   always_comb begin
      if (sim_enable_ff) begin
         res_mag     = sim_mag;
         res_neg_sel = sim_value_ff[SMW-1];
      end else if (below_deadband) begin
         res_mag     = '0;
         res_neg_sel = 1'b0;
      end else begin
         res_mag     = quot_ff[SMW-1:0];
         res_neg_sel = sum_neg_ff;
      end
   end

   // Sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      fill_count_in = fill_count_ff;
      was_full_in   = was_full_ff;
      sum_in        = sum_ff;
      sample_in     = sample_ff;
      sum_neg_in    = sum_neg_ff;
      res_neg_in    = res_neg_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      digit_in      = digit_ff;
      result_in     = result_ff;
      rsp_ma_in     = rsp_ma_ff;
      rsp_deci_in   = rsp_deci_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         cmad_pkg::ST_IDLE: begin
            if (req_beat) begin
               sample_in   = req_sample_ma;
               was_full_in = (fill_count_ff == CW'(WINDOW));
               if (fill_count_ff != CW'(WINDOW)) begin
                  fill_count_in = fill_count_ff + 1'b1;
               end
               if (write_slot_ff == AW'(WINDOW - 1)) begin
                  write_slot_in = '0;
               end else begin
                  write_slot_in = write_slot_ff + 1'b1;
               end
               state_in = cmad_pkg::ST_SUM;
            end
         end
         cmad_pkg::ST_SUM: begin
            // add the new sample, drop the evicted one once the ring is full
            if (was_full_ff) begin
               sum_in = sum_ff + SW'(sample_ff) - SW'(evict_ff);
            end else begin
               sum_in = sum_ff + SW'(sample_ff);
            end
            state_in = cmad_pkg::ST_LOAD;
         end
         cmad_pkg::ST_LOAD: begin
            quot_in    = sum_mag;
            sum_neg_in = sum_sat[QW-1];
            rem_in     = '0;
            divisor_in = DW'(fill_count_ff);
            digit_in   = '0;
            state_in   = cmad_pkg::ST_DIV1;
         end
         cmad_pkg::ST_DIV1: begin
            quot_in  = quot_step;
            rem_in   = rem_step;
            digit_in = digit_ff + 1'b1;
            if (last_digit) begin
               state_in = cmad_pkg::ST_DEAD;
            end
         end
         cmad_pkg::ST_DEAD: begin
            result_in  = res_neg_sel ? SMW'(-res_mag) : SMW'(res_mag);
            res_neg_in = res_neg_sel;
            quot_in    = QW'(res_mag);
            rem_in     = '0;
            divisor_in = DW'(cmad_pkg::DECI_DIVISOR);
            digit_in   = '0;
            state_in   = cmad_pkg::ST_DIV2;
         end
         cmad_pkg::ST_DIV2: begin
            quot_in  = quot_step;
            rem_in   = rem_step;
            digit_in = digit_ff + 1'b1;
            if (last_digit) begin
               state_in = cmad_pkg::ST_FIN;
            end
         end
         cmad_pkg::ST_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_ma_in    = result_ff;
               rsp_deci_in  = res_neg_ff ? -quot_ff[cmad_pkg::DECI_W-1:0]
                                         : quot_ff[cmad_pkg::DECI_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = cmad_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cmad_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cmad_pkg::ST_IDLE;
         write_slot_ff <= '0;
         fill_count_ff <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         fill_count_ff <= fill_count_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      was_full_ff <= was_full_in;
      sample_ff   <= sample_in;
      sum_neg_ff  <= sum_neg_in;
      res_neg_ff  <= res_neg_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      digit_ff    <= digit_in;
      result_ff   <= result_in;
      rsp_ma_ff   <= rsp_ma_in;
      rsp_deci_ff <= rsp_deci_in;
   end

   // Checks
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == cmad_pkg::ST_FIN))
      else $error("rsp_valid rose outside the output cycle");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CW'(WINDOW))
      else $error("fill count exceeds the window");

   a_beat_starts_sum: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == cmad_pkg::ST_SUM) && (fill_count_ff != '0))
      else $error("accepted beat did not start a sum update");

   a_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("rsp_valid high right after reset");

endmodule

`default_nettype wire
